>>> rtl/rbci_pkg.sv
// shared types, constants and collision microprogram of the rigid body impulse unit
package rbci_pkg;

  localparam int NUM_BODIES_DEF    = 16;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int BODY_STRIDE       = 16;
  localparam int SCRATCH_WORDS     = 32;
  localparam int PC_W              = 8;

  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_READ    = 2'd1;
  localparam logic [1:0] OP_COLLIDE = 2'd2;

  localparam logic [2:0] ATTR_POS  = 3'd0;
  localparam logic [2:0] ATTR_MASS = 3'd4;

  // word offsets inside one body record
  localparam int W_PX = 0;
  localparam int W_PY = 1;
  localparam int W_PZ = 2;
  localparam int W_MX = 3;
  localparam int W_MY = 4;
  localparam int W_MZ = 5;
  localparam int W_VX = 6;
  localparam int W_VY = 7;
  localparam int W_VZ = 8;
  localparam int W_SX = 9;
  localparam int W_SY = 10;
  localparam int W_SZ = 11;
  localparam int W_IM = 12;
  localparam int W_II = 13;

  // item operand slots
  localparam int I_CX = 0;
  localparam int I_CY = 1;
  localparam int I_CZ = 2;
  localparam int I_NX = 3;
  localparam int I_NY = 4;
  localparam int I_NZ = 5;
  localparam int I_E  = 6;

  localparam int K_ZERO = 0;
  localparam int K_ONE  = 1;

  typedef enum logic [2:0] {ALU_ADD, ALU_SUB, ALU_MUL, ALU_DIV, ALU_END} alu_e;
  typedef enum logic [2:0] {SEL_B1, SEL_B2, SEL_SCR, SEL_IN, SEL_K} sel_e;

  typedef struct packed {
    sel_e       sel;
    logic [4:0] off;
  } opnd_t;

  typedef struct packed {
    alu_e  op;
    opnd_t d;
    opnd_t a;
    opnd_t b;
  } uop_t;

  function automatic opnd_t b1(input int o);
    return '{SEL_B1, 5'(o)};
  endfunction

  function automatic opnd_t b2(input int o);
    return '{SEL_B2, 5'(o)};
  endfunction

  function automatic opnd_t sc(input int o);
    return '{SEL_SCR, 5'(o)};
  endfunction

  function automatic opnd_t ip(input int o);
    return '{SEL_IN, 5'(o)};
  endfunction

  function automatic opnd_t kc(input int o);
    return '{SEL_K, 5'(o)};
  endfunction

  function automatic uop_t u(input alu_e op, input opnd_t d, input opnd_t a, input opnd_t b);
    return '{op, d, a, b};
  endfunction

  function automatic uop_t ucode(input logic [PC_W-1:0] pc);
    uop_t r;
    case (pc)
      // arm of first body
      8'd0:   r = u(ALU_ADD, sc(0), b1(W_PX), b1(W_MX));
      8'd1:   r = u(ALU_ADD, sc(1), b1(W_PY), b1(W_MY));
      8'd2:   r = u(ALU_ADD, sc(2), b1(W_PZ), b1(W_MZ));
      8'd3:   r = u(ALU_SUB, sc(3), ip(I_CX), sc(0));
      8'd4:   r = u(ALU_SUB, sc(4), ip(I_CY), sc(1));
      8'd5:   r = u(ALU_SUB, sc(5), ip(I_CZ), sc(2));
      // arm of second body
      8'd6:   r = u(ALU_ADD, sc(0), b2(W_PX), b2(W_MX));
      8'd7:   r = u(ALU_ADD, sc(1), b2(W_PY), b2(W_MY));
      8'd8:   r = u(ALU_ADD, sc(2), b2(W_PZ), b2(W_MZ));
      8'd9:   r = u(ALU_SUB, sc(6), ip(I_CX), sc(0));
      8'd10:  r = u(ALU_SUB, sc(7), ip(I_CY), sc(1));
      8'd11:  r = u(ALU_SUB, sc(8), ip(I_CZ), sc(2));
      // point velocity of first body
      8'd12:  r = u(ALU_MUL, sc(9),  b1(W_SY), sc(5));
      8'd13:  r = u(ALU_MUL, sc(10), b1(W_SZ), sc(4));
      8'd14:  r = u(ALU_SUB, sc(11), sc(9), sc(10));
      8'd15:  r = u(ALU_MUL, sc(9),  b1(W_SZ), sc(3));
      8'd16:  r = u(ALU_MUL, sc(10), b1(W_SX), sc(5));
      8'd17:  r = u(ALU_SUB, sc(12), sc(9), sc(10));
      8'd18:  r = u(ALU_MUL, sc(9),  b1(W_SX), sc(4));
      8'd19:  r = u(ALU_MUL, sc(10), b1(W_SY), sc(3));
      8'd20:  r = u(ALU_SUB, sc(13), sc(9), sc(10));
      8'd21:  r = u(ALU_ADD, sc(11), b1(W_VX), sc(11));
      8'd22:  r = u(ALU_ADD, sc(12), b1(W_VY), sc(12));
      8'd23:  r = u(ALU_ADD, sc(13), b1(W_VZ), sc(13));
      // point velocity of second body
      8'd24:  r = u(ALU_MUL, sc(9),  b2(W_SY), sc(8));
      8'd25:  r = u(ALU_MUL, sc(10), b2(W_SZ), sc(7));
      8'd26:  r = u(ALU_SUB, sc(14), sc(9), sc(10));
      8'd27:  r = u(ALU_MUL, sc(9),  b2(W_SZ), sc(6));
      8'd28:  r = u(ALU_MUL, sc(10), b2(W_SX), sc(8));
      8'd29:  r = u(ALU_SUB, sc(15), sc(9), sc(10));
      8'd30:  r = u(ALU_MUL, sc(9),  b2(W_SX), sc(7));
      8'd31:  r = u(ALU_MUL, sc(10), b2(W_SY), sc(6));
      8'd32:  r = u(ALU_SUB, sc(16), sc(9), sc(10));
      8'd33:  r = u(ALU_ADD, sc(14), b2(W_VX), sc(14));
      8'd34:  r = u(ALU_ADD, sc(15), b2(W_VY), sc(15));
      8'd35:  r = u(ALU_ADD, sc(16), b2(W_VZ), sc(16));
      // relative velocity
      8'd36:  r = u(ALU_SUB, sc(11), sc(14), sc(11));
      8'd37:  r = u(ALU_SUB, sc(12), sc(15), sc(12));
      8'd38:  r = u(ALU_SUB, sc(13), sc(16), sc(13));
      // numerator
      8'd39:  r = u(ALU_ADD, sc(9), kc(K_ONE), ip(I_E));
      8'd40:  r = u(ALU_SUB, sc(9), kc(K_ZERO), sc(9));
      8'd41:  r = u(ALU_MUL, sc(11), sc(11), sc(9));
      8'd42:  r = u(ALU_MUL, sc(12), sc(12), sc(9));
      8'd43:  r = u(ALU_MUL, sc(13), sc(13), sc(9));
      8'd44:  r = u(ALU_MUL, sc(14), sc(11), ip(I_NX));
      8'd45:  r = u(ALU_MUL, sc(15), sc(12), ip(I_NY));
      8'd46:  r = u(ALU_ADD, sc(14), sc(14), sc(15));
      8'd47:  r = u(ALU_MUL, sc(15), sc(13), ip(I_NZ));
      8'd48:  r = u(ALU_ADD, sc(14), sc(14), sc(15));
      // first arm cross normal
      8'd49:  r = u(ALU_MUL, sc(9),  sc(4), ip(I_NZ));
      8'd50:  r = u(ALU_MUL, sc(10), sc(5), ip(I_NY));
      8'd51:  r = u(ALU_SUB, sc(17), sc(9), sc(10));
      8'd52:  r = u(ALU_MUL, sc(9),  sc(5), ip(I_NX));
      8'd53:  r = u(ALU_MUL, sc(10), sc(3), ip(I_NZ));
      8'd54:  r = u(ALU_SUB, sc(18), sc(9), sc(10));
      8'd55:  r = u(ALU_MUL, sc(9),  sc(3), ip(I_NY));
      8'd56:  r = u(ALU_MUL, sc(10), sc(4), ip(I_NX));
      8'd57:  r = u(ALU_SUB, sc(19), sc(9), sc(10));
      // second arm cross normal
      8'd58:  r = u(ALU_MUL, sc(9),  sc(7), ip(I_NZ));
      8'd59:  r = u(ALU_MUL, sc(10), sc(8), ip(I_NY));
      8'd60:  r = u(ALU_SUB, sc(20), sc(9), sc(10));
      8'd61:  r = u(ALU_MUL, sc(9),  sc(8), ip(I_NX));
      8'd62:  r = u(ALU_MUL, sc(10), sc(6), ip(I_NZ));
      8'd63:  r = u(ALU_SUB, sc(21), sc(9), sc(10));
      8'd64:  r = u(ALU_MUL, sc(9),  sc(6), ip(I_NY));
      8'd65:  r = u(ALU_MUL, sc(10), sc(7), ip(I_NX));
      8'd66:  r = u(ALU_SUB, sc(22), sc(9), sc(10));
      // inertia term of first body
      8'd67:  r = u(ALU_MUL, sc(23), sc(17), b1(W_II));
      8'd68:  r = u(ALU_MUL, sc(24), sc(18), b1(W_II));
      8'd69:  r = u(ALU_MUL, sc(25), sc(19), b1(W_II));
      8'd70:  r = u(ALU_MUL, sc(9),  sc(24), sc(5));
      8'd71:  r = u(ALU_MUL, sc(10), sc(25), sc(4));
      8'd72:  r = u(ALU_SUB, sc(26), sc(9), sc(10));
      8'd73:  r = u(ALU_MUL, sc(9),  sc(25), sc(3));
      8'd74:  r = u(ALU_MUL, sc(10), sc(23), sc(5));
      8'd75:  r = u(ALU_SUB, sc(27), sc(9), sc(10));
      8'd76:  r = u(ALU_MUL, sc(9),  sc(23), sc(4));
      8'd77:  r = u(ALU_MUL, sc(10), sc(24), sc(3));
      8'd78:  r = u(ALU_SUB, sc(28), sc(9), sc(10));
      // inertia term of second body
      8'd79:  r = u(ALU_MUL, sc(23), sc(20), b2(W_II));
      8'd80:  r = u(ALU_MUL, sc(24), sc(21), b2(W_II));
      8'd81:  r = u(ALU_MUL, sc(25), sc(22), b2(W_II));
      8'd82:  r = u(ALU_MUL, sc(9),  sc(24), sc(8));
      8'd83:  r = u(ALU_MUL, sc(10), sc(25), sc(7));
      8'd84:  r = u(ALU_SUB, sc(29), sc(9), sc(10));
      8'd85:  r = u(ALU_MUL, sc(9),  sc(25), sc(6));
      8'd86:  r = u(ALU_MUL, sc(10), sc(23), sc(8));
      8'd87:  r = u(ALU_SUB, sc(30), sc(9), sc(10));
      8'd88:  r = u(ALU_MUL, sc(9),  sc(23), sc(7));
      8'd89:  r = u(ALU_MUL, sc(10), sc(24), sc(6));
      8'd90:  r = u(ALU_SUB, sc(31), sc(9), sc(10));
      // denominator
      8'd91:  r = u(ALU_ADD, sc(26), sc(26), sc(29));
      8'd92:  r = u(ALU_ADD, sc(27), sc(27), sc(30));
      8'd93:  r = u(ALU_ADD, sc(28), sc(28), sc(31));
      8'd94:  r = u(ALU_MUL, sc(23), sc(26), ip(I_NX));
      8'd95:  r = u(ALU_MUL, sc(24), sc(27), ip(I_NY));
      8'd96:  r = u(ALU_ADD, sc(23), sc(23), sc(24));
      8'd97:  r = u(ALU_MUL, sc(24), sc(28), ip(I_NZ));
      8'd98:  r = u(ALU_ADD, sc(23), sc(23), sc(24));
      8'd99:  r = u(ALU_ADD, sc(25), b1(W_IM), b2(W_IM));
      8'd100: r = u(ALU_ADD, sc(25), sc(25), sc(23));
      8'd101: r = u(ALU_DIV, sc(9), sc(14), sc(25));
      // impulse along normal
      8'd102: r = u(ALU_MUL, sc(10), ip(I_NX), sc(9));
      8'd103: r = u(ALU_MUL, sc(11), ip(I_NY), sc(9));
      8'd104: r = u(ALU_MUL, sc(12), ip(I_NZ), sc(9));
      // linear velocities
      8'd105: r = u(ALU_MUL, sc(13), sc(10), b1(W_IM));
      8'd106: r = u(ALU_SUB, b1(W_VX), b1(W_VX), sc(13));
      8'd107: r = u(ALU_MUL, sc(13), sc(11), b1(W_IM));
      8'd108: r = u(ALU_SUB, b1(W_VY), b1(W_VY), sc(13));
      8'd109: r = u(ALU_MUL, sc(13), sc(12), b1(W_IM));
      8'd110: r = u(ALU_SUB, b1(W_VZ), b1(W_VZ), sc(13));
      8'd111: r = u(ALU_MUL, sc(13), sc(10), b2(W_IM));
      8'd112: r = u(ALU_ADD, b2(W_VX), b2(W_VX), sc(13));
      8'd113: r = u(ALU_MUL, sc(13), sc(11), b2(W_IM));
      8'd114: r = u(ALU_ADD, b2(W_VY), b2(W_VY), sc(13));
      8'd115: r = u(ALU_MUL, sc(13), sc(12), b2(W_IM));
      8'd116: r = u(ALU_ADD, b2(W_VZ), b2(W_VZ), sc(13));
      // spins
      8'd117: r = u(ALU_MUL, sc(13), b1(W_II), sc(9));
      8'd118: r = u(ALU_MUL, sc(15), sc(17), sc(13));
      8'd119: r = u(ALU_SUB, b1(W_SX), b1(W_SX), sc(15));
      8'd120: r = u(ALU_MUL, sc(15), sc(18), sc(13));
      8'd121: r = u(ALU_SUB, b1(W_SY), b1(W_SY), sc(15));
      8'd122: r = u(ALU_MUL, sc(15), sc(19), sc(13));
      8'd123: r = u(ALU_SUB, b1(W_SZ), b1(W_SZ), sc(15));
      8'd124: r = u(ALU_MUL, sc(13), b2(W_II), sc(9));
      8'd125: r = u(ALU_MUL, sc(15), sc(20), sc(13));
      8'd126: r = u(ALU_ADD, b2(W_SX), b2(W_SX), sc(15));
      8'd127: r = u(ALU_MUL, sc(15), sc(21), sc(13));
      8'd128: r = u(ALU_ADD, b2(W_SY), b2(W_SY), sc(15));
      8'd129: r = u(ALU_MUL, sc(15), sc(22), sc(13));
      8'd130: r = u(ALU_ADD, b2(W_SZ), b2(W_SZ), sc(15));
      default: r = u(ALU_END, sc(0), sc(0), sc(0));
    endcase
    return r;
  endfunction

  function automatic logic [31:0] sat33(input logic [32:0] s);
    logic [31:0] r;
    if (s[32] != s[31]) begin
      r = s[32] ? 32'h8000_0000 : 32'h7fff_ffff;
    end else begin
      r = s[31:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/rbci_ram.sv
// generic synchronous ram, one write port and two registered read ports
module rbci_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 288
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

>>> rtl/rbci_div.sv
// radix-2 restoring divider for the impulse quotient, saturated to 32 bits
module rbci_div #(
  parameter int FRACTION_BITS = rbci_pkg::FRACTION_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] numer_i,
  input  logic [31:0] denom_i,
  output logic        done_o,
  output logic [31:0] quot_o
);

  localparam int NW = 32 + FRACTION_BITS;
  localparam int CW = $clog2(NW + 1);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic          neg_q;
  logic [31:0]   dvs_q;
  logic [31:0]   rem_q;
  logic [NW-1:0] acc_q;

  logic [31:0] n_mag;
  logic [31:0] d_mag;
  logic [32:0] rem_sh;
  logic        fits;
  logic [32:0] rem_nx;

  assign n_mag  = numer_i[31] ? (~numer_i + 32'd1) : numer_i;
  assign d_mag  = denom_i[31] ? (~denom_i + 32'd1) : denom_i;
  assign rem_sh = {rem_q, acc_q[NW-1]};
  assign fits   = rem_sh >= {1'b0, dvs_q};
  assign rem_nx = fits ? (rem_sh - {1'b0, dvs_q}) : rem_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= numer_i[31] ^ denom_i[31];
      dvs_q <= d_mag;
      rem_q <= '0;
      acc_q <= NW'(n_mag) << FRACTION_BITS;
    end else if (busy_q) begin
      rem_q <= rem_nx[31:0];
      acc_q <= {acc_q[NW-2:0], fits};
    end
  end

  always_comb begin
    if (!neg_q) begin
      quot_o = (acc_q > NW'(32'h7fff_ffff)) ? 32'h7fff_ffff : acc_q[31:0];
    end else begin
      quot_o = (acc_q > NW'(32'h8000_0000)) ? 32'h8000_0000 : (~acc_q[31:0] + 32'd1);
    end
  end

  assign done_o = done_q;

endmodule

>>> rtl/rigid_body_collision_impulse_unit.sv
// top level of the rigid body collision impulse unit: body store, sequencer and datapath
//
// All body state sits in one two-read-port ram (16 words per body plus 32 scratch
// words) and every item is worked by a sequencer around a shared saturating adder
// and a registered 32x32 multiplier. One item is taken at a time. A collision runs
// its 131 micro-operations, each read from the store, executed and written back, with
// the divide step waiting on the divider; it ends early, marked degenerate, when the
// denominator is zero. An item naming a body outside the table, a read or write of an
// attribute beyond mass, or no operation, goes straight to its answer. After reset the
// body words are cleared, one a cycle, before the first item is taken.
module rigid_body_collision_impulse_unit #(
  parameter int NUM_BODIES    = rbci_pkg::NUM_BODIES_DEF,
  parameter int FRACTION_BITS = rbci_pkg::FRACTION_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [3:0]  first_body_i,
  input  logic [3:0]  second_body_i,
  input  logic [2:0]  attribute_i,
  input  logic [31:0] vector_x_i,
  input  logic [31:0] vector_y_i,
  input  logic [31:0] vector_z_i,
  input  logic [31:0] normal_x_i,
  input  logic [31:0] normal_y_i,
  input  logic [31:0] normal_z_i,
  input  logic [16:0] elasticity_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] read_x_o,
  output logic [31:0] read_y_o,
  output logic [31:0] read_z_o,
  output logic [31:0] impulse_o,
  output logic        degenerate_o
);

  localparam int BODY_WORDS = NUM_BODIES * rbci_pkg::BODY_STRIDE;
  localparam int DEPTH      = BODY_WORDS + rbci_pkg::SCRATCH_WORDS;
  localparam int AW         = $clog2(DEPTH);
  localparam logic [31:0] FX_ONE = 32'(1) << FRACTION_BITS;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_WR, S_RD_ISS, S_RD_CAP, S_U_RD, S_U_EX, S_U_WB, S_DIV, S_DONE
  } state_e;

  state_e                     state_q;
  logic [AW-1:0]              clr_q;
  logic [rbci_pkg::PC_W-1:0]  pc_q;
  logic [1:0]                 k_q;
  logic                       out_valid_q;
  logic                       deg_q;

  logic [3:0]  b1_q, b2_q;
  logic [2:0]  attr_q;
  logic [31:0] vx_q, vy_q, vz_q, nx_q, ny_q, nz_q;
  logic [16:0] e_q;
  logic [31:0] rx_q, ry_q, rz_q, imp_q;
  logic [31:0] out_x_q, out_y_q, out_z_q, out_imp_q;
  logic        out_deg_q;
  logic [32:0] sum_q;
  logic [63:0] prod_q;

  rbci_pkg::uop_t uop;
  logic          we;
  logic [AW-1:0] waddr, raddr_a, raddr_b;
  logic [31:0]   wdata, rdata_a, rdata_b;
  logic [31:0]   opa, opb, wb_val;
  logic [3:0]    acc_word;
  logic [1:0]    k_last;
  logic          div_start, div_done;
  logic [31:0]   div_q;
  logic [63:0]   shp;
  logic          b1_ok, b2_ok;

  function automatic logic [AW-1:0] body_addr(input logic [3:0] b, input logic [3:0] w);
    return AW'(32'(b) * rbci_pkg::BODY_STRIDE + 32'(w));
  endfunction

  function automatic logic [AW-1:0] addr_of(input rbci_pkg::opnd_t o, input logic [3:0] p,
                                            input logic [3:0] s);
    logic [AW-1:0] r;
    case (o.sel)
      rbci_pkg::SEL_B1:  r = body_addr(p, o.off[3:0]);
      rbci_pkg::SEL_B2:  r = body_addr(s, o.off[3:0]);
      rbci_pkg::SEL_SCR: r = AW'(BODY_WORDS + 32'(o.off));
      default:           r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] pick(input rbci_pkg::opnd_t o, input logic [31:0] mem,
                                       input logic [31:0] cx, input logic [31:0] cy,
                                       input logic [31:0] cz, input logic [31:0] qx,
                                       input logic [31:0] qy, input logic [31:0] qz,
                                       input logic [16:0] el);
    logic [31:0] r;
    case (o.sel)
      rbci_pkg::SEL_IN: begin
        case (32'(o.off))
          rbci_pkg::I_CX: r = cx;
          rbci_pkg::I_CY: r = cy;
          rbci_pkg::I_CZ: r = cz;
          rbci_pkg::I_NX: r = qx;
          rbci_pkg::I_NY: r = qy;
          rbci_pkg::I_NZ: r = qz;
          rbci_pkg::I_E:  r = {15'd0, el};
          default:        r = '0;
        endcase
      end
      rbci_pkg::SEL_K: r = (32'(o.off) == rbci_pkg::K_ONE) ? FX_ONE : 32'd0;
      default:         r = mem;
    endcase
    return r;
  endfunction

  assign uop      = rbci_pkg::ucode(pc_q);
  assign acc_word = (attr_q == rbci_pkg::ATTR_MASS) ? 4'(rbci_pkg::W_IM + 32'(k_q))
                                                    : 4'(32'(attr_q) * 3 + 32'(k_q));
  assign k_last   = (attr_q == rbci_pkg::ATTR_MASS) ? 2'd1 : 2'd2;
  assign b1_ok    = 32'(first_body_i) < NUM_BODIES;
  assign b2_ok    = 32'(second_body_i) < NUM_BODIES;

  assign opa = pick(uop.a, rdata_a, vx_q, vy_q, vz_q, nx_q, ny_q, nz_q, e_q);
  assign opb = pick(uop.b, rdata_b, vx_q, vy_q, vz_q, nx_q, ny_q, nz_q, e_q);

  assign shp = $signed(prod_q) >>> FRACTION_BITS;

  always_comb begin
    if (uop.op == rbci_pkg::ALU_MUL) begin
      if ($signed(shp) > $signed(64'h0000_0000_7fff_ffff)) begin
        wb_val = 32'h7fff_ffff;
      end else if ($signed(shp) < $signed(64'hffff_ffff_8000_0000)) begin
        wb_val = 32'h8000_0000;
      end else begin
        wb_val = shp[31:0];
      end
    end else begin
      wb_val = rbci_pkg::sat33(sum_q);
    end
  end

  assign div_start = (state_q == S_U_EX) && (uop.op == rbci_pkg::ALU_DIV) && (opb != 32'd0);

  always_comb begin
    we      = 1'b0;
    waddr   = '0;
    wdata   = '0;
    raddr_a = '0;
    raddr_b = '0;
    case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
      end
      S_WR: begin
        we    = 1'b1;
        waddr = body_addr(b1_q, acc_word);
        wdata = (k_q == 2'd0) ? vx_q : ((k_q == 2'd1) ? vy_q : vz_q);
      end
      S_RD_ISS: begin
        raddr_a = body_addr(b1_q, acc_word);
      end
      S_U_RD: begin
        raddr_a = addr_of(uop.a, b1_q, b2_q);
        raddr_b = addr_of(uop.b, b1_q, b2_q);
      end
      S_U_WB: begin
        we    = 1'b1;
        waddr = addr_of(uop.d, b1_q, b2_q);
        wdata = wb_val;
      end
      S_DIV: begin
        we    = div_done;
        waddr = addr_of(uop.d, b1_q, b2_q);
        wdata = div_q;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  rbci_ram #(
    .WIDTH(32),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .raddr_a_i(raddr_a),
    .rdata_a_o(rdata_a),
    .raddr_b_i(raddr_b),
    .rdata_b_o(rdata_b)
  );

  rbci_div #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .numer_i(opa),
    .denom_i(opb),
    .done_o (div_done),
    .quot_o (div_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      pc_q        <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      deg_q       <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(BODY_WORDS - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            b1_q   <= first_body_i;
            b2_q   <= second_body_i;
            attr_q <= attribute_i;
            vx_q   <= vector_x_i;
            vy_q   <= vector_y_i;
            vz_q   <= vector_z_i;
            nx_q   <= normal_x_i;
            ny_q   <= normal_y_i;
            nz_q   <= normal_z_i;
            e_q    <= elasticity_i;
            rx_q   <= '0;
            ry_q   <= '0;
            rz_q   <= '0;
            imp_q  <= '0;
            deg_q  <= 1'b0;
            k_q    <= '0;
            pc_q   <= '0;
            state_q <= S_DONE;
            case (operation_i)
              rbci_pkg::OP_WRITE: begin
                if (b1_ok && attribute_i <= rbci_pkg::ATTR_MASS) begin
                  state_q <= S_WR;
                end
              end
              rbci_pkg::OP_READ: begin
                if (b1_ok && attribute_i <= rbci_pkg::ATTR_MASS) begin
                  state_q <= S_RD_ISS;
                end
              end
              rbci_pkg::OP_COLLIDE: begin
                if (b1_ok && b2_ok) begin
                  state_q <= S_U_RD;
                end
              end
              default: begin
                state_q <= S_DONE;
              end
            endcase
          end
        end
        S_WR: begin
          if (k_q == k_last) begin
            state_q <= S_DONE;
          end else begin
            k_q <= k_q + 2'd1;
          end
        end
        S_RD_ISS: begin
          state_q <= S_RD_CAP;
        end
        S_RD_CAP: begin
          case (k_q)
            2'd0:    rx_q <= rdata_a;
            2'd1:    ry_q <= rdata_a;
            default: rz_q <= rdata_a;
          endcase
          if (k_q == k_last) begin
            state_q <= S_DONE;
          end else begin
            k_q     <= k_q + 2'd1;
            state_q <= S_RD_ISS;
          end
        end
        S_U_RD: begin
          state_q <= (uop.op == rbci_pkg::ALU_END) ? S_DONE : S_U_EX;
        end
        S_U_EX: begin
          sum_q  <= (uop.op == rbci_pkg::ALU_SUB) ? (33'($signed(opa)) - 33'($signed(opb)))
                                                  : (33'($signed(opa)) + 33'($signed(opb)));
          prod_q <= 64'($signed(opa)) * 64'($signed(opb));
          if (uop.op == rbci_pkg::ALU_DIV) begin
            if (opb == 32'd0) begin
              deg_q   <= 1'b1;
              state_q <= S_DONE;
            end else begin
              state_q <= S_DIV;
            end
          end else begin
            state_q <= S_U_WB;
          end
        end
        S_U_WB: begin
          pc_q    <= pc_q + 1'b1;
          state_q <= S_U_RD;
        end
        S_DIV: begin
          if (div_done) begin
            imp_q   <= div_q;
            pc_q    <= pc_q + 1'b1;
            state_q <= S_U_RD;
          end
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_x_q     <= rx_q;
            out_y_q     <= ry_q;
            out_z_q     <= rz_q;
            out_imp_q   <= imp_q;
            out_deg_q   <= deg_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign read_x_o     = out_x_q;
  assign read_y_o     = out_y_q;
  assign read_z_o     = out_z_q;
  assign impulse_o    = out_imp_q;
  assign degenerate_o = out_deg_q;

  // one item in flight at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("item taken while another is in flight");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && degenerate_o) |-> (impulse_o == 32'd0))
    else $error("degenerate collision with nonzero impulse");

  a_div_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider finished outside the divide step");

  a_no_mem_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !we)
    else $error("body store written while idle");

endmodule

>>> bench/tb_top.sv
// self-checking testbench of the rigid body collision impulse unit
module tb_top;

  localparam logic [1:0] OP_NONE     = 2'd3;
  localparam logic [2:0] ATTR_CENTRE = 3'd1;
  localparam logic [2:0] ATTR_VEL    = 3'd2;
  localparam logic [2:0] ATTR_SPIN   = 3'd3;
  localparam int         FX_ONE      = 65536;
  localparam int         STALL_LIMIT = 5000;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } v3_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  b1;
    logic [3:0]  b2;
    logic [2:0]  attr;
    v3_t         v;
    v3_t         n;
    logic [16:0] e;
  } body_item_t;

  typedef struct packed {
    v3_t                rd;
    logic signed [31:0] imp;
    logic               degen;
  } body_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  operation_i = '0;
  logic [3:0]  first_body_i = '0;
  logic [3:0]  second_body_i = '0;
  logic [2:0]  attribute_i = '0;
  logic [31:0] vector_x_i = '0;
  logic [31:0] vector_y_i = '0;
  logic [31:0] vector_z_i = '0;
  logic [31:0] normal_x_i = '0;
  logic [31:0] normal_y_i = '0;
  logic [31:0] normal_z_i = '0;
  logic [16:0] elasticity_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] read_x_o;
  logic [31:0] read_y_o;
  logic [31:0] read_z_o;
  logic [31:0] impulse_o;
  logic        degenerate_o;

  rigid_body_collision_impulse_unit DUT (.*);

  v3_t                position [16];
  v3_t                centre   [16];
  v3_t                velocity [16];
  v3_t                spin     [16];
  logic signed [31:0] inv_mass [16];
  logic signed [31:0] inv_inert[16];

  body_item_t   pending_items[$];
  body_result_t awaited_results[$];
  body_item_t   cur_item;
  int           total_items;
  int           accepted_items = 0;
  int           stall_cycles = 0;
  bit           failed = 1'b0;

  function automatic logic signed [31:0] clamp(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fff_ffff;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] qadd(input logic signed [31:0] a, b);
    return clamp(longint'(a) + longint'(b));
  endfunction

  function automatic logic signed [31:0] qsub(input logic signed [31:0] a, b);
    return clamp(longint'(a) - longint'(b));
  endfunction

  function automatic logic signed [31:0] qmul(input logic signed [31:0] a, b);
    longint p;
    p = longint'(a) * longint'(b);
    return clamp(p >>> 16);
  endfunction

  function automatic v3_t vsum(input v3_t a, b);
    return '{qadd(a.x, b.x), qadd(a.y, b.y), qadd(a.z, b.z)};
  endfunction

  function automatic v3_t vdiff(input v3_t a, b);
    return '{qsub(a.x, b.x), qsub(a.y, b.y), qsub(a.z, b.z)};
  endfunction

  function automatic v3_t vscl(input v3_t a, input logic signed [31:0] s);
    return '{qmul(a.x, s), qmul(a.y, s), qmul(a.z, s)};
  endfunction

  function automatic v3_t vcrs(input v3_t a, b);
    return '{qsub(qmul(a.y, b.z), qmul(a.z, b.y)),
             qsub(qmul(a.z, b.x), qmul(a.x, b.z)),
             qsub(qmul(a.x, b.y), qmul(a.y, b.x))};
  endfunction

  function automatic logic signed [31:0] vdt(input v3_t a, b);
    return qadd(qadd(qmul(a.x, b.x), qmul(a.y, b.y)), qmul(a.z, b.z));
  endfunction

  function automatic v3_t inertia_term(input int b, input v3_t r, n);
    return vcrs(vscl(vcrs(r, n), inv_inert[b]), r);
  endfunction

  task automatic predict_result(input body_item_t it);
    body_result_t       res;
    v3_t                r1, r2, rel, jn, d;
    logic signed [31:0] negk, numer, denom;
    int                 b1, b2;
    res = '0;
    b1 = it.b1;
    b2 = it.b2;
    case (it.op)
      rbci_pkg::OP_WRITE: begin
        case (it.attr)
          rbci_pkg::ATTR_POS: position[b1] = it.v;
          ATTR_CENTRE:        centre[b1] = it.v;
          ATTR_VEL:           velocity[b1] = it.v;
          ATTR_SPIN:          spin[b1] = it.v;
          rbci_pkg::ATTR_MASS: begin
            inv_mass[b1] = it.v.x;
            inv_inert[b1] = it.v.y;
          end
          default: ;
        endcase
      end
      rbci_pkg::OP_READ: begin
        case (it.attr)
          rbci_pkg::ATTR_POS:  res.rd = position[b1];
          ATTR_CENTRE:         res.rd = centre[b1];
          ATTR_VEL:            res.rd = velocity[b1];
          ATTR_SPIN:           res.rd = spin[b1];
          rbci_pkg::ATTR_MASS: res.rd = '{inv_mass[b1], inv_inert[b1], 32'sd0};
          default: ;
        endcase
      end
      rbci_pkg::OP_COLLIDE: begin
        r1 = vdiff(it.v, vsum(position[b1], centre[b1]));
        r2 = vdiff(it.v, vsum(position[b2], centre[b2]));
        rel = vdiff(vsum(velocity[b2], vcrs(spin[b2], r2)),
                    vsum(velocity[b1], vcrs(spin[b1], r1)));
        negk = clamp(-longint'(qadd(FX_ONE, signed'({15'd0, it.e}))));
        numer = vdt(vscl(rel, negk), it.n);
        denom = qadd(qadd(inv_mass[b1], inv_mass[b2]),
                     vdt(vsum(inertia_term(b1, r1, it.n), inertia_term(b2, r2, it.n)), it.n));
        if (denom == 0) begin
          res.degen = 1'b1;
        end else begin
          res.imp = clamp((longint'(numer) * FX_ONE) / longint'(denom));
          jn = vscl(it.n, res.imp);
          velocity[b1] = vdiff(velocity[b1], vscl(jn, inv_mass[b1]));
          velocity[b2] = vsum(velocity[b2], vscl(jn, inv_mass[b2]));
          d = vscl(vcrs(r1, it.n), qmul(inv_inert[b1], res.imp));
          spin[b1] = vdiff(spin[b1], d);
          d = vscl(vcrs(r2, it.n), qmul(inv_inert[b2], res.imp));
          spin[b2] = vsum(spin[b2], d);
        end
      end
      default: ;
    endcase
    awaited_results.push_back(res);
  endtask

  function automatic logic signed [31:0] rand_fx();
    int k;
    k = $urandom_range(0, 99);
    if (k < 55) return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
    if (k < 70) begin
      case ($urandom_range(0, 3))
        0: return 32'sh7fff_ffff;
        1: return 32'sh8000_0000;
        2: return 32'sd0;
        default: return FX_ONE;
      endcase
    end
    return $urandom;
  endfunction

  function automatic v3_t rand_v3();
    return '{rand_fx(), rand_fx(), rand_fx()};
  endfunction

  task automatic add_item(input logic [1:0] op, input int b1, b2, input logic [2:0] attr,
                          input v3_t v, n, input int e);
    pending_items.push_back('{op, 4'(b1), 4'(b2), attr, v, n, 17'(e)});
  endtask

  initial begin
    v3_t nrm, vmax, vmin;
    int  k;
    for (int b = 0; b < 16; b++) begin
      position[b] = '0; centre[b] = '0; velocity[b] = '0; spin[b] = '0;
      inv_mass[b] = '0; inv_inert[b] = '0;
    end
    nrm = '{FX_ONE, 32'sd0, 32'sd0};
    vmax = '{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff};
    vmin = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
    // directed part
    add_item(rbci_pkg::OP_WRITE, 0, 0, rbci_pkg::ATTR_POS, '{FX_ONE, 2 * FX_ONE, 0}, '0, 0);
    add_item(rbci_pkg::OP_WRITE, 0, 0, ATTR_CENTRE, '{0, FX_ONE / 2, 0}, '0, 0);
    add_item(rbci_pkg::OP_WRITE, 0, 0, ATTR_VEL, '{3 * FX_ONE, 0, -FX_ONE}, '0, 0);
    add_item(rbci_pkg::OP_WRITE, 0, 0, ATTR_SPIN, '{0, 0, FX_ONE}, '0, 0);
    add_item(rbci_pkg::OP_WRITE, 0, 0, rbci_pkg::ATTR_MASS, '{FX_ONE, FX_ONE / 2, 7}, '0, 0);
    add_item(rbci_pkg::OP_WRITE, 1, 0, ATTR_VEL, '{-2 * FX_ONE, FX_ONE, 0}, '0, 0);
    add_item(rbci_pkg::OP_WRITE, 1, 0, rbci_pkg::ATTR_MASS, '{FX_ONE / 4, FX_ONE, 0}, '0, 0);
    add_item(rbci_pkg::OP_WRITE, 0, 0, 3'd6, vmax, '0, 0);
    for (int a = 0; a < 8; a++) add_item(rbci_pkg::OP_READ, 0, 0, 3'(a), '0, '0, 0);
    add_item(rbci_pkg::OP_COLLIDE, 0, 1, rbci_pkg::ATTR_POS, '{FX_ONE, 0, 0}, nrm, 0);
    add_item(rbci_pkg::OP_COLLIDE, 0, 1, rbci_pkg::ATTR_POS, '{0, FX_ONE, FX_ONE}, nrm,
             FX_ONE);
    add_item(rbci_pkg::OP_COLLIDE, 3, 4, rbci_pkg::ATTR_POS, '{FX_ONE, 0, 0}, nrm,
             FX_ONE / 2);
    add_item(rbci_pkg::OP_COLLIDE, 1, 1, rbci_pkg::ATTR_POS, '{0, 0, FX_ONE},
             '{0, FX_ONE, 0}, 17'h1ffff);
    add_item(rbci_pkg::OP_COLLIDE, 0, 1, rbci_pkg::ATTR_POS, vmin, vmax, 17'h1ffff);
    add_item(OP_NONE, 15, 15, 3'd7, vmax, vmin, 17'h1ffff);
    add_item(rbci_pkg::OP_WRITE, 15, 0, rbci_pkg::ATTR_POS, vmin, '0, 0);
    add_item(rbci_pkg::OP_READ, 15, 0, rbci_pkg::ATTR_POS, '0, '0, 0);
    add_item(rbci_pkg::OP_READ, 0, 0, ATTR_VEL, '0, '0, 0);
    // well-formed bodies first, then random traffic
    for (int b = 0; b < 16; b++)
      add_item(rbci_pkg::OP_WRITE, b, 0, rbci_pkg::ATTR_MASS,
               '{$urandom_range(1, 2 * FX_ONE), $urandom_range(0, 2 * FX_ONE), 0}, '0, 0);
    for (int i = 0; i < 1600; i++) begin
      k = $urandom_range(0, 99);
      if (k < 35) begin
        k = $urandom_range(0, 19);
        if (k == 0) add_item(rbci_pkg::OP_WRITE, $urandom_range(0, 15), 0,
                             3'($urandom_range(5, 7)), rand_v3(), rand_v3(), $urandom);
        else if (k < 4) add_item(rbci_pkg::OP_WRITE, $urandom_range(0, 15),
                                 $urandom_range(0, 15), rbci_pkg::ATTR_MASS,
                                 '{$urandom_range(0, 2 * FX_ONE),
                                 $urandom_range(0, 2 * FX_ONE), $urandom}, '0, 0);
        else add_item(rbci_pkg::OP_WRITE, $urandom_range(0, 15), $urandom_range(0, 15),
                      3'($urandom_range(0, 4)), rand_v3(), rand_v3(), $urandom);
      end else if (k < 60) begin
        add_item(rbci_pkg::OP_READ, $urandom_range(0, 15), $urandom_range(0, 15),
                 3'($urandom_range(0, 7)), rand_v3(), rand_v3(), $urandom);
      end else if (k < 96) begin
        add_item(rbci_pkg::OP_COLLIDE, $urandom_range(0, 15), $urandom_range(0, 15),
                 3'($urandom), rand_v3(), rand_v3(),
                 ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, FX_ONE));
      end else begin
        add_item(OP_NONE, $urandom_range(0, 15), $urandom_range(0, 15), 3'($urandom),
                 rand_v3(), rand_v3(), $urandom);
      end
    end
    total_items = pending_items.size();
    while (pending_items.size() > 0 || in_valid_i || awaited_results.size() > 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (!failed) begin
      $display("[rigid_body_collision_impulse_unit] OK");
    end else begin
      $display("[rigid_body_collision_impulse_unit] ERROR");
    end
    $finish;
  end

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic int send_idle_pct();
    int ph;
    ph = (total_items == 0) ? 0 : accepted_items * 3 / total_items;
    return (ph == 0) ? 18 : (ph == 1) ? 69 : 0;
  endfunction

  function automatic int recv_idle_pct();
    int ph;
    ph = (total_items == 0) ? 0 : accepted_items * 3 / total_items;
    return (ph == 0) ? 69 : (ph == 1) ? 18 : 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_result(cur_item);
        accepted_items++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
          cur_item = pending_items.pop_front();
          operation_i   <= cur_item.op;
          first_body_i  <= cur_item.b1;
          second_body_i <= cur_item.b2;
          attribute_i   <= cur_item.attr;
          vector_x_i    <= cur_item.v.x;
          vector_y_i    <= cur_item.v.y;
          vector_z_i    <= cur_item.v.z;
          normal_x_i    <= cur_item.n.x;
          normal_y_i    <= cur_item.n.y;
          normal_z_i    <= cur_item.n.z;
          elasticity_i  <= cur_item.e;
          in_valid_i    <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    body_result_t exp_res, act;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        act = '{'{read_x_o, read_y_o, read_z_o}, impulse_o, degenerate_o};
        if (awaited_results.size() == 0) begin
          $display("%0t unexpected item: got %h", $time, act);
          failed = 1'b1;
        end else begin
          exp_res = awaited_results.pop_front();
          if (act.rd.x !== exp_res.rd.x)
            $display("%0t read_x expected %h got %h", $time, exp_res.rd.x, act.rd.x);
          if (act.rd.y !== exp_res.rd.y)
            $display("%0t read_y expected %h got %h", $time, exp_res.rd.y, act.rd.y);
          if (act.rd.z !== exp_res.rd.z)
            $display("%0t read_z expected %h got %h", $time, exp_res.rd.z, act.rd.z);
          if (act.imp !== exp_res.imp)
            $display("%0t impulse expected %h got %h", $time, exp_res.imp, act.imp);
          if (act.degen !== exp_res.degen)
            $display("%0t degenerate expected %b got %b", $time, exp_res.degen, act.degen);
          if (act !== exp_res) failed = 1'b1;
        end
      end
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct());
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("[rigid_body_collision_impulse_unit] ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule
